[rtl/stlb_pkg.sv]
// Package for the small translation buffer: sizes, field types, codes and
// the structs that pass between the buffer's modules. No dependencies.
package stlb_pkg;

  localparam int unsigned Entries = 4;
  localparam int unsigned FieldW  = 20;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned OccW    = $clog2(Entries + 1);

  typedef logic [FieldW-1:0] field_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [OccW-1:0]   occ_t;

  typedef enum logic {
    OpLookup = 1'b0,
    OpInsert = 1'b1
  } op_e;

  typedef enum logic {
    ModeFifo = 1'b0,
    ModeLru  = 1'b1
  } mode_e;

  // Update request to the entry store. Slots from..last-1 take the next
  // younger slot when shift is set; slot last takes the new pair when wr is set.
  typedef struct packed {
    logic   wr;
    logic   shift;
    idx_t   from;
    idx_t   last;
    field_t page;
    field_t frame;
    logic   inc;
  } upd_t;

  typedef struct packed {
    logic   hit;
    idx_t   idx;
    field_t frame;
  } match_t;

endpackage

[rtl/stlb_match.sv]
// Parallel page compare over the valid entries with oldest-first priority.
// Depends on stlb_pkg.
module stlb_match (
  input  stlb_pkg::field_t                        page_i,
  input  stlb_pkg::field_t [stlb_pkg::Entries-1:0] pages_i,
  input  stlb_pkg::field_t [stlb_pkg::Entries-1:0] frames_i,
  input  stlb_pkg::occ_t                          occ_i,
  output stlb_pkg::match_t                        match_o
);
  import stlb_pkg::*;

  // Walk from the youngest slot down so that the oldest match wins.
  always_comb begin
    match_o = '0;
    for (int k = Entries - 1; k >= 0; k--) begin
      if ((OccW'(k) < occ_i) && (pages_i[k] == page_i)) begin
        match_o.hit   = 1'b1;
        match_o.idx   = IdxW'(k);
        match_o.frame = frames_i[k];
      end
    end
  end

endmodule

[rtl/stlb_store.sv]
// Entry store of the translation buffer: page and frame slots in age order
// with the shift network for inserts and LRU promotion. Depends on stlb_pkg.
module stlb_store (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  stlb_pkg::upd_t                          upd_i,
  output stlb_pkg::field_t [stlb_pkg::Entries-1:0] pages_o,
  output stlb_pkg::field_t [stlb_pkg::Entries-1:0] frames_o,
  output stlb_pkg::occ_t                          occ_o
);
  import stlb_pkg::*;

  field_t [Entries-1:0] pages_q;
  field_t [Entries-1:0] pages_d;
  field_t [Entries-1:0] frames_q;
  field_t [Entries-1:0] frames_d;
  occ_t                 occ_q;
  occ_t                 occ_d;

  // Slots in from..last-1 age by one, then slot last takes the new pair.
  always_comb begin
    pages_d  = pages_q;
    frames_d = frames_q;
    for (int k = 0; k < Entries - 1; k++) begin
      if (upd_i.shift && (IdxW'(k) >= upd_i.from) && (IdxW'(k) < upd_i.last)) begin
        pages_d[k]  = pages_q[k+1];
        frames_d[k] = frames_q[k+1];
      end
    end
    if (upd_i.wr) begin
      pages_d[upd_i.last]  = upd_i.page;
      frames_d[upd_i.last] = upd_i.frame;
    end
  end

  always_ff @(posedge clk_i) begin
    pages_q  <= pages_d;
    frames_q <= frames_d;
  end

  assign occ_d = upd_i.inc ? occ_q + OccW'(1) : occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign pages_o  = pages_q;
  assign frames_o = frames_q;
  assign occ_o    = occ_q;

endmodule

[rtl/small_tlb_fifo_lru.sv]
// Top level of the small fully associative translation buffer: input and
// result registers around the compare logic and the entry store.
// Depends on stlb_pkg, stlb_match and stlb_store.
//
// The buffer takes one item in every clock cycle and never raises busy_o. An
// item accepted at one clock edge is compared against the entries in the
// following cycle, and its result shows on hit_o and found_frame_o with
// done_o high for exactly one cycle, right after the next clock edge. The
// rate is set by the combinational compare and the shift of the entry
// store. The receiver cannot
// stall, so done_o must be sampled whenever it is high.
module small_tlb_fifo_lru (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             operation_i,
  input  stlb_pkg::field_t page_i,
  input  stlb_pkg::field_t frame_i,
  input  logic             replace_mode_we_i,
  input  logic             replace_mode_i,
  output logic             done_o,
  output logic             hit_o,
  output stlb_pkg::field_t found_frame_o
);
  import stlb_pkg::*;

  logic   req_q;
  op_e    op_q;
  field_t page_q;
  field_t frame_q;
  mode_e  mode_q;

  logic   done_q;
  logic   hit_q;
  field_t found_q;

  field_t [Entries-1:0] pages;
  field_t [Entries-1:0] frames;
  occ_t                 occ;
  match_t               match;
  upd_t                 upd;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= 1'b0;
      mode_q <= ModeFifo;
      done_q <= 1'b0;
    end else begin
      req_q  <= start_i;
      done_q <= req_q;
      if (replace_mode_we_i) begin
        mode_q <= mode_e'(replace_mode_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q    <= op_e'(operation_i);
      page_q  <= page_i;
      frame_q <= frame_i;
    end
  end

  stlb_match u_match (
    .page_i   (page_q),
    .pages_i  (pages),
    .frames_i (frames),
    .occ_i    (occ),
    .match_o  (match)
  );

  always_comb begin
    upd       = '0;
    upd.page  = page_q;
    upd.frame = frame_q;
    if (req_q) begin
      if (op_q == OpInsert) begin
        upd.wr = 1'b1;
        if (occ == OccW'(Entries)) begin
          // Full: the oldest pair drops out and the rest age by one slot.
          upd.shift = 1'b1;
          upd.last  = IdxW'(Entries - 1);
        end else begin
          upd.last = occ[IdxW-1:0];
          upd.inc  = 1'b1;
        end
      end else if (match.hit && (mode_q == ModeLru)) begin
        upd.wr    = 1'b1;
        upd.shift = 1'b1;
        upd.from  = match.idx;
        upd.last  = IdxW'(occ - OccW'(1));
        upd.frame = match.frame;
      end
    end
  end

  stlb_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .pages_o  (pages),
    .frames_o (frames),
    .occ_o    (occ)
  );

  always_ff @(posedge clk_i) begin
    if (req_q) begin
      hit_q   <= (op_q == OpLookup) && match.hit;
      found_q <= ((op_q == OpLookup) && match.hit) ? match.frame : '0;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign found_frame_o = found_q;

endmodule

[rtl/stlb_checker.sv]
// Port-level checker for the translation buffer and its bind to the top level.
// Depends on stlb_pkg and small_tlb_fifo_lru.
module stlb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             operation_i,
  input logic             done_o,
  input logic             hit_o,
  input stlb_pkg::field_t found_frame_o
);
  import stlb_pkg::*;

  // Every accepted item yields its result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted item produced no result");

  // No result without an accepted item before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted item");

  // A miss or insert reports frame zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (found_frame_o == '0))
    else $error("nonzero frame on a miss");

  // An insert never reports a hit.
  a_insert_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == OpInsert)) |-> ##2 !hit_o)
    else $error("insert reported a hit");

endmodule

bind small_tlb_fifo_lru stlb_checker u_stlb_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the small translation buffer small_tlb_fifo_lru.
// A clocked driver and monitor run against an in-bench predictor of the entry
// store. Depends on stlb_pkg and the buffer's RTL only.
module tb_top;
  import stlb_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 245;
  localparam int unsigned MaxReported = 10;

  typedef enum logic [1:0] {
    ReqItem,
    ReqMode,
    ReqDrain,
    ReqPace
  } req_kind_e;

  typedef struct {
    req_kind_e   kind;
    op_e         op;
    field_t      page;
    field_t      frame;
    mode_e       mode;
    int unsigned idle_pct;
  } tlb_req_t;

  typedef struct packed {
    logic   hit;
    field_t frame;
  } tlb_resp_t;

  logic   clk         = 1'b0;
  logic   rst_n       = 1'b0;
  logic   start       = 1'b0;
  op_e    op_sel      = OpLookup;
  field_t page        = '0;
  field_t frame       = '0;
  logic   mode_we     = 1'b0;
  mode_e  mode_sel    = ModeFifo;
  logic   busy;
  logic   done;
  logic   hit;
  field_t found_frame;

  tlb_req_t    pending_q[$];
  tlb_resp_t   expected_q[$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_pct     = 0;

  // Predicted contents of the buffer, slot 0 the oldest.
  field_t model_pages[Entries];
  field_t model_frames[Entries];
  int     model_fill = 0;
  mode_e  model_mode = ModeFifo;

  small_tlb_fifo_lru i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .operation_i       (op_sel),
    .page_i            (page),
    .frame_i           (frame),
    .replace_mode_we_i (mode_we),
    .replace_mode_i    (mode_sel),
    .done_o            (done),
    .hit_o             (hit),
    .found_frame_o     (found_frame)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic tlb_resp_t predict_access(op_e acc_op, field_t pg, field_t fr);
    tlb_resp_t res;
    bit        found;
    int        k;
    int        j;
    res = '0;
    if (acc_op == OpInsert) begin
      if (model_fill < Entries) begin
        model_pages[model_fill]  = pg;
        model_frames[model_fill] = fr;
        model_fill++;
      end else begin
        for (k = 0; k < Entries - 1; k++) begin
          model_pages[k]  = model_pages[k+1];
          model_frames[k] = model_frames[k+1];
        end
        model_pages[Entries-1]  = pg;
        model_frames[Entries-1] = fr;
      end
      return res;
    end
    found = 1'b0;
    for (k = 0; k < model_fill && !found; k++) begin
      if (model_pages[k] == pg) begin
        found     = 1'b1;
        res.hit   = 1'b1;
        res.frame = model_frames[k];
        if (model_mode == ModeLru) begin
          for (j = k; j < model_fill - 1; j++) begin
            model_pages[j]  = model_pages[j+1];
            model_frames[j] = model_frames[j+1];
          end
          model_pages[model_fill-1]  = pg;
          model_frames[model_fill-1] = res.frame;
        end
      end
    end
    return res;
  endfunction

  task automatic add_item(op_e acc_op, field_t pg, field_t fr);
    pending_q.push_back('{ReqItem, acc_op, pg, fr, ModeFifo, 0});
  endtask

  task automatic add_mode(mode_e m);
    pending_q.push_back('{ReqDrain, OpLookup, '0, '0, ModeFifo, 0});
    pending_q.push_back('{ReqMode, OpLookup, '0, '0, m, 0});
  endtask

  task automatic add_pace(int unsigned pct);
    pending_q.push_back('{ReqPace, OpLookup, '0, '0, ModeFifo, pct});
  endtask

  // Mostly pages from a small pool so that hits, duplicates and evictions are
  // frequent; the rest are fully random pages that almost always miss.
  task automatic add_random_phase(int unsigned n);
    field_t pool[6];
    field_t pg;
    op_e    acc_op;
    int     i;
    for (i = 0; i < 6; i++) pool[i] = field_t'($urandom);
    pool[0] = $urandom_range(1) ? '0 : '1;
    for (i = 0; i < n; i++) begin
      if (i == n / 2) begin
        pending_q.push_back('{ReqDrain, OpLookup, '0, '0, ModeFifo, 0});
      end
      acc_op = ($urandom_range(99) < 40) ? OpInsert : OpLookup;
      pg = ($urandom_range(9) < 8) ? pool[$urandom_range(5)] : field_t'($urandom);
      add_item(acc_op, pg, field_t'($urandom));
    end
  endtask

  task automatic log_mismatch(string what, logic [FieldW-1:0] want, logic [FieldW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("Mismatch on %s after %0d results: expected %h, got %h",
               what, results_seen, want, got);
    end
  endtask

  // Driver: presents one queued request per cycle unless the idle percentage or a
  // drain holds it back, and records the expected result of every item that the buffer accepts.
  always @(posedge clk) begin : drive_items
    tlb_req_t head;
    logic     nxt_start;
    logic     nxt_we;
    bit       drained;
    if (rst_n) begin
      if (mode_we) begin
        model_mode = mode_sel;
      end
      if (start && !busy) begin
        expected_q.push_back(predict_access(op_sel, page, frame));
        items_sent++;
      end
      nxt_start = start && busy;
      nxt_we    = 1'b0;
      drained   = (results_seen >= items_sent);
      if (!nxt_start && pending_q.size() > 0) begin
        head = pending_q[0];
        case (head.kind)
          ReqItem: begin
            if ($urandom_range(99) >= idle_pct) begin
              void'(pending_q.pop_front());
              op_sel    <= head.op;
              page      <= head.page;
              frame     <= head.frame;
              nxt_start = 1'b1;
            end
          end
          ReqMode: begin
            if (drained) begin
              void'(pending_q.pop_front());
              mode_sel <= head.mode;
              nxt_we   = 1'b1;
            end
          end
          ReqDrain: begin
            if (drained) begin
              void'(pending_q.pop_front());
            end
          end
          default: begin
            idle_pct = head.idle_pct;
            void'(pending_q.pop_front());
          end
        endcase
      end
      start   <= nxt_start;
      mode_we <= nxt_we;
    end
  end

  // Monitor: every cycle with done high carries one result.
  always @(posedge clk) begin : check_results
    tlb_resp_t want;
    if (rst_n && done) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        log_mismatch("unexpected result", '0, found_frame);
      end else begin
        want = expected_q.pop_front();
        if (hit !== want.hit) begin
          log_mismatch("hit", FieldW'(want.hit), FieldW'(hit));
        end
        if (found_frame !== want.frame) begin
          log_mismatch("found_frame", want.frame, found_frame);
        end
      end
    end
  end

  initial begin : stimulus
    int p;
    add_pace(0);
    add_mode(ModeFifo);
    add_item(OpLookup, '0, '1);
    add_item(OpInsert, '0, '1);
    add_item(OpInsert, '1, '0);
    add_item(OpLookup, '1, 20'h3c3c3);
    add_item(OpLookup, '0, '0);
    add_item(OpLookup, 20'h5a5a5, '0);
    // Duplicate page: the older entry must win the lookup.
    add_item(OpInsert, '0, 20'h55555);
    add_item(OpLookup, '0, '0);
    add_item(OpInsert, 20'haaaaa, 20'h12345);
    // Buffer is full here, so this insert drops the oldest entry.
    add_item(OpInsert, 20'h55555, 20'haaaaa);
    add_item(OpLookup, '0, '0);
    add_item(OpLookup, '1, '0);
    add_item(OpInsert, 20'h00001, 20'h80000);
    add_mode(ModeLru);
    add_item(OpLookup, '0, '0);
    add_item(OpInsert, 20'h12345, 20'h00001);
    add_item(OpLookup, 20'haaaaa, '0);
    add_item(OpLookup, 20'h12345, '1);
    add_item(OpLookup, '1, '0);
    add_item(OpInsert, 20'h77777, 20'h33333);
    add_item(OpLookup, 20'h55555, '0);
    add_item(OpLookup, '0, '0);
    for (p = 0; p < 4; p++) begin
      add_mode((p % 2 == 0) ? ModeLru : ModeFifo);
      case (p)
        1:       add_pace(86);
        3:       add_pace(11);
        default: add_pace(0);
      endcase
      add_random_phase(PhaseItems);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_q.size() != 0 || start || results_seen < items_sent) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles", CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/stlb_pkg.sv
rtl/stlb_match.sv
rtl/stlb_store.sv
rtl/small_tlb_fifo_lru.sv
rtl/stlb_checker.sv
tb/tb_top.sv
